[src/assert_macros.svh]
// Assertion macros shared by the receiver modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, checked outside reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

// Invariant, checked outside reset
`define ASSERT_ALWAYS(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("invariant check failed");

`endif

[src/urx_pkg.sv]
// Shared types, constants and helper functions for the sampled UART receiver
`timescale 1ns / 1ps

package urx_pkg;

  // Field and register widths
  localparam int TIMER_BITS = 17;
  localparam int TPB_W      = 16;
  localparam int DBITS_W    = 4;
  localparam int PMODE_W    = 3;
  localparam int BYTE_W     = 8;
  localparam int IDX_W      = 4;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int LOAD_W     = TPB_W + 2;
  localparam int CMP_W      = (TIMER_BITS > LOAD_W) ? TIMER_BITS : LOAD_W;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TICKS_PER_BIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DATA_BITS     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PARITY_MODE   = 2'd2;

  // Register reset values
  localparam logic [TPB_W-1:0]   TPB_RESET   = 16'd16;
  localparam logic [DBITS_W-1:0] DBITS_RESET = 4'd8;

  // Data bit limits
  localparam logic [DBITS_W-1:0] DBITS_MIN = 4'd5;
  localparam logic [DBITS_W-1:0] DBITS_MAX = 4'd8;

  // Parity modes
  localparam logic [PMODE_W-1:0] PAR_NONE  = 3'd0;
  localparam logic [PMODE_W-1:0] PAR_EVEN  = 3'd1;
  localparam logic [PMODE_W-1:0] PAR_ODD   = 3'd2;
  localparam logic [PMODE_W-1:0] PAR_MARK  = 3'd3;
  localparam logic [PMODE_W-1:0] PAR_SPACE = 3'd4;

  // Receiver state
  typedef enum logic {
    ST_IDLE,
    ST_FRAME
  } state_t;

  // Effective configuration seen by the frame logic
  typedef struct packed {
    logic [TIMER_BITS-1:0] start_load;
    logic [TIMER_BITS-1:0] bit_load;
    logic [DBITS_W-1:0]    nbits;
    logic [PMODE_W-1:0]    mode;
  } cfg_t;

  // One finished byte from the frame logic
  typedef struct packed {
    logic              valid;
    logic [BYTE_W-1:0] data;
  } res_t;

  // Clamp a load value to the largest timer value
  function automatic logic [TIMER_BITS-1:0] sat_timer(input logic [LOAD_W-1:0] v);
    logic [CMP_W-1:0] wide;
    logic [CMP_W-1:0] maxv;
    wide = CMP_W'(v);
    maxv = CMP_W'({TIMER_BITS{1'b1}});
    if (wide > maxv) begin
      sat_timer = TIMER_BITS'(maxv);
    end else begin
      sat_timer = TIMER_BITS'(wide);
    end
  endfunction

  // Mask of the valid data bits for an effective bit count
  function automatic logic [BYTE_W-1:0] data_mask(input logic [DBITS_W-1:0] nb);
    case (nb)
      4'd5:    data_mask = 8'h1F;
      4'd6:    data_mask = 8'h3F;
      4'd7:    data_mask = 8'h7F;
      default: data_mask = 8'hFF;
    endcase
  endfunction

endpackage

[src/urx_cfg.sv]
// Configuration registers and effective timing and format values
`timescale 1ns / 1ps

module urx_cfg (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [urx_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [urx_pkg::CFG_DATA_W-1:0]    cfg_data,
  output urx_pkg::cfg_t                     cfg
);
  import urx_pkg::*;

  logic [TPB_W-1:0]   ticks_per_bit;
  logic [DBITS_W-1:0] data_bits;
  logic [PMODE_W-1:0] parity_mode;
  logic [TPB_W-1:0]   period;
  logic [LOAD_W-1:0]  half_up;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      ticks_per_bit <= TPB_RESET;
      data_bits     <= DBITS_RESET;
      parity_mode   <= PAR_NONE;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_TICKS_PER_BIT: ticks_per_bit <= cfg_data[TPB_W-1:0];
        REG_DATA_BITS:     data_bits     <= cfg_data[DBITS_W-1:0];
        REG_PARITY_MODE:   parity_mode   <= cfg_data[PMODE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    // Bit period of zero acts as one; start wait is 1.5 periods rounded up
    period  = (ticks_per_bit == '0) ? TPB_W'(1) : ticks_per_bit;
    half_up = (LOAD_W'(period) + LOAD_W'(1)) >> 1;
    cfg.start_load = sat_timer(LOAD_W'(period) + half_up);
    cfg.bit_load   = sat_timer(LOAD_W'(period));

    // Clamp data bits and map unknown parity codes to none
    if (data_bits < DBITS_MIN) begin
      cfg.nbits = DBITS_MIN;
    end else if (data_bits > DBITS_MAX) begin
      cfg.nbits = DBITS_MAX;
    end else begin
      cfg.nbits = data_bits;
    end
    cfg.mode = (parity_mode > PAR_SPACE) ? PAR_NONE : parity_mode;
  end

endmodule

[src/urx_frame.sv]
// Frame state machine: start detect, bit timing, data shift, parity and stop check
`timescale 1ns / 1ps

module urx_frame (
  input  logic           clk,
  input  logic           rst,
  input  logic           step,
  input  logic           level,
  input  urx_pkg::cfg_t  cfg,
  output urx_pkg::res_t  res
);
  import urx_pkg::*;
  `include "assert_macros.svh"

  state_t                state, state_next;
  logic                  prev_level, prev_level_next;
  logic [IDX_W-1:0]      bit_index, bit_index_next;
  logic [BYTE_W-1:0]     shift_byte, shift_byte_next;
  logic [TIMER_BITS-1:0] bit_timer, bit_timer_next;

  logic [BYTE_W-1:0]     mask;
  logic                  sample_now;
  logic                  in_data;
  logic                  in_parity;
  logic                  want_parity;

  // Decode the current bit slot
  always_comb begin
    mask       = data_mask(cfg.nbits);
    sample_now = (state == ST_FRAME) && (bit_timer <= TIMER_BITS'(1));
    in_data    = bit_index < cfg.nbits;
    in_parity  = !in_data && (cfg.mode != PAR_NONE) && (bit_index == cfg.nbits);
    case (cfg.mode)
      PAR_EVEN: want_parity = ^(shift_byte & mask);
      PAR_ODD:  want_parity = ~(^(shift_byte & mask));
      PAR_MARK: want_parity = 1'b1;
      default:  want_parity = 1'b0;
    endcase
  end

  // Next state
  always_comb begin
    state_next      = state;
    prev_level_next = prev_level;
    bit_index_next  = bit_index;
    shift_byte_next = shift_byte;
    bit_timer_next  = bit_timer;
    if (step) begin
      prev_level_next = level;
      case (state)
        ST_IDLE: begin
          if (prev_level && !level) begin
            state_next      = ST_FRAME;
            bit_index_next  = '0;
            shift_byte_next = '0;
            bit_timer_next  = cfg.start_load;
          end
        end
        ST_FRAME: begin
          if (!sample_now) begin
            bit_timer_next = bit_timer - TIMER_BITS'(1);
          end else begin
            bit_timer_next = cfg.bit_load;
            if (in_data) begin
              if (level) begin
                shift_byte_next = shift_byte | (BYTE_W'(1) << bit_index[2:0]);
              end
              bit_index_next = bit_index + IDX_W'(1);
            end else if (in_parity && (level == want_parity)) begin
              bit_index_next = bit_index + IDX_W'(1);
            end else begin
              // bad parity or stop slot: frame ends either way
              state_next     = ST_IDLE;
              bit_index_next = '0;
            end
          end
        end
        default: state_next = ST_IDLE;
      endcase
    end
  end

  // Result: stop slot sampled high
  always_comb begin
    res.valid = step && sample_now && !in_data && !in_parity && level;
    res.data  = shift_byte & mask;
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      prev_level <= 1'b1;
      bit_index  <= '0;
      shift_byte <= '0;
      bit_timer  <= '0;
    end else begin
      state      <= state_next;
      prev_level <= prev_level_next;
      bit_index  <= bit_index_next;
      shift_byte <= shift_byte_next;
      bit_timer  <= bit_timer_next;
    end
  end

  `ASSERT_IMPLIES(a_idle_index_clear, clk, rst, state == ST_IDLE, bit_index == '0)
  `ASSERT_IMPLIES(a_frame_timer_live, clk, rst, state == ST_FRAME, bit_timer != '0)
  `ASSERT_ALWAYS(a_index_bound, clk, rst, bit_index <= DBITS_MAX + IDX_W'(1))
  `ASSERT_IMPLIES(a_result_ends_frame, clk, rst, res.valid, state_next == ST_IDLE)

endmodule

[src/urx_outq.sv]
// Two-slot output queue: result register plus skid slot
`timescale 1ns / 1ps

module urx_outq (
  input  logic                           clk,
  input  logic                           rst,
  input  urx_pkg::res_t                  res,
  output logic                           space,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [urx_pkg::BYTE_W-1:0]     rx_byte
);
  import urx_pkg::*;
  `include "assert_macros.svh"

  logic              skid_valid;
  logic [BYTE_W-1:0] skid_byte;
  logic              pop;

  assign pop   = out_valid && out_ready;
  assign space = !skid_valid;

  // Valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        skid_valid <= 1'b0;
      end
    end else if (out_valid && !pop) begin
      skid_valid <= res.valid;
    end else begin
      out_valid <= res.valid;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) begin
        rx_byte <= skid_byte;
      end
    end else if (out_valid && !pop) begin
      if (res.valid) begin
        skid_byte <= res.data;
      end
    end else if (res.valid) begin
      rx_byte <= res.data;
    end
  end

  `ASSERT_IMPLIES(a_skid_behind_out, clk, rst, skid_valid, out_valid)
  `ASSERT_NEXT(a_skid_moves_up, clk, rst, skid_valid && pop, out_valid && !skid_valid)
  `ASSERT_IMPLIES(a_no_write_when_full, clk, rst, skid_valid, !res.valid)

endmodule

[src/uart_sampled_receiver.sv]
// Sampled UART receiver: 5 to 8 data bits, optional parity, one stop bit.
// Feed one thresholded line sample per transfer on the input channel; each
// sample counts as one tick. A falling edge while idle starts a frame, the
// first data bit is taken 1.5 bit periods later (rounded up) and each later
// bit one period after that. A byte whose parity and stop bit are good comes
// out on the output channel; bad frames are dropped without notice. The frame
// state is registered on the clock edge that ends the cycle in which a sample
// is transferred, and a finished byte enters the two-slot output queue on that
// same edge. in_ready drops only while both queue slots hold bytes not yet
// taken. Write configuration only while no frame is in progress.
`timescale 1ns / 1ps

module uart_sampled_receiver (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [urx_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [urx_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              line_level,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [urx_pkg::BYTE_W-1:0]        rx_byte
);
  import urx_pkg::*;

  cfg_t cfg;
  res_t res;
  logic step;

  // Sample transfer
  assign step = in_valid && in_ready;

  urx_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  urx_frame u_frame (
    .clk   (clk),
    .rst   (rst),
    .step  (step),
    .level (line_level),
    .cfg   (cfg),
    .res   (res)
  );

  urx_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .res       (res),
    .space     (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .rx_byte   (rx_byte)
  );

endmodule
